// File: design/hc2_pkg.sv
// Shared types, key constants and letter arithmetic for the 2x2 Hill cipher core.
package hc2_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned VAL_W  = 7;   // a letter value, 0..95
  localparam int unsigned SUM_W  = 12;  // largest keyed sum is 2660
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // The only register sits at byte address 0; bit 2 set is beyond the map.
  localparam logic [ADDR_W-1:0] REG_DECRYPT_ADDR = 3'h0;

  // Key matrices. The off-diagonal entries are shared by both directions.
  localparam logic [SUM_W-1:0] KEY_ENC_DIAG = 12'd3;
  localparam logic [SUM_W-1:0] KEY_DEC_DIAG = 12'd23;
  localparam logic [SUM_W-1:0] KEY_K01      = 12'd5;
  localparam logic [SUM_W-1:0] KEY_K10      = 12'd2;

  // ceil(2^16 / 26); exact floor quotient for every sum below 4096.
  localparam logic [23:0] RECIP_26 = 24'd2521;
  localparam logic [SUM_W-1:0] ALPHA_MOD = 12'd26;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_CASE    = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_BEFORE_A = 8'h60;
  localparam logic [CHAR_W-1:0] LETTER_MOD   = 8'd96;
  localparam logic [CHAR_W-1:0] LETTER_MOD2  = 8'd192;

  typedef struct packed {
    logic              lone;       // lone final byte, passed through
    logic              last;
    logic [CHAR_W-1:0] lone_char;
    logic [SUM_W-1:0]  sum0;
    logic [SUM_W-1:0]  sum1;
  } job_t;

  // Lower-case an upper-case ASCII letter, then reduce modulo 96.
  function automatic logic [VAL_W-1:0] letter_value(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] v;
    v = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      v = b + CHAR_CASE;
    end
    if (v >= LETTER_MOD2) begin
      v = v - LETTER_MOD2;
    end else if (v >= LETTER_MOD) begin
      v = v - LETTER_MOD;
    end
    return v[VAL_W-1:0];
  endfunction

  // Reduce a keyed sum modulo 26 and map 1..25 to a..y, 0 to z.
  function automatic logic [CHAR_W-1:0] to_letter(input logic [SUM_W-1:0] s);
    logic [23:0]      prod;
    logic [SUM_W-1:0] q;
    logic [SUM_W-1:0] r;
    prod = {12'b0, s} * RECIP_26;
    q    = {4'b0, prod[23:16]};
    r    = s - SUM_W'(q * ALPHA_MOD);
    if (r[4:0] == 5'd0) begin
      return CHAR_LOWER_Z;
    end
    return CHAR_BEFORE_A + {3'b0, r[4:0]};
  endfunction

endpackage

// File: design/hc2_in_if.sv
// Input byte channel: valid/ready handshake with a text byte and its end mark.
interface hc2_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_in;

  modport source (output valid, output char_in, output last_in, input ready);
  modport sink (input valid, input char_in, input last_in, output ready);
  modport monitor (input valid, input ready, input char_in, input last_in);
endinterface

// File: design/hc2_out_if.sv
// Result byte channel: valid/ready handshake with a result byte and its end mark.
interface hc2_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_out;

  modport source (output valid, output char_out, output last_out, input ready);
  modport sink (input valid, input char_out, input last_out, output ready);
  modport monitor (input valid, input ready, input char_out, input last_out);
endinterface

// File: design/hc2_cfg.sv
// APB-style configuration register holding the decrypt select.
module hc2_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hc2_pkg::ADDR_W-1:0] paddr,
  input  logic [hc2_pkg::DATA_W-1:0] pwdata,
  output logic [hc2_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output logic                      decrypt_o
);
  import hc2_pkg::*;

  logic decrypt_q, decrypt_d;
  logic hit;

  // Byte offsets 0..3 all fall on the one register.
  assign hit    = (paddr[ADDR_W-1] == REG_DECRYPT_ADDR[ADDR_W-1]);
  assign pready = 1'b1;

  always_comb begin
    decrypt_d = decrypt_q;
    if (psel && penable && pwrite && pready && hit) begin
      decrypt_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(DATA_W-1){1'b0}}, decrypt_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
    end else begin
      decrypt_q <= decrypt_d;
    end
  end

  assign decrypt_o = decrypt_q;
endmodule

// File: design/hc2_pair.sv
// Pairing front end: holds the first byte and forms the keyed sums of a pair.
module hc2_pair (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [hc2_pkg::CHAR_W-1:0] char_i,
  input  logic                      last_i,
  input  logic                      decrypt_i,
  input  logic                      job_free_i,
  output logic                      ready_o,
  output logic                      job_load_o,
  output hc2_pkg::job_t             job_o
);
  import hc2_pkg::*;

  logic              holding_q, holding_d;
  logic [CHAR_W-1:0] held_q, held_d;
  logic [SUM_W-1:0]  m0, m1, kdiag;
  logic              accept;

  // A byte that is merely held needs no room downstream.
  assign ready_o    = job_free_i || (!holding_q && !last_i);
  assign accept     = valid_i && ready_o;
  assign job_load_o = accept && (holding_q || last_i);

  always_comb begin
    m0    = {5'b0, letter_value(held_q)};
    m1    = {5'b0, letter_value(char_i)};
    kdiag = decrypt_i ? KEY_DEC_DIAG : KEY_ENC_DIAG;
    job_o.lone      = !holding_q;
    job_o.last      = last_i;
    job_o.lone_char = char_i;
    job_o.sum0      = SUM_W'(m0 * kdiag) + SUM_W'(m1 * KEY_K10);
    job_o.sum1      = SUM_W'(m0 * KEY_K01) + SUM_W'(m1 * kdiag);
  end

  always_comb begin
    holding_d = holding_q;
    held_d    = held_q;
    if (accept) begin
      holding_d = !holding_q && !last_i;
      if (!holding_q && !last_i) begin
        held_d = char_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q <= 1'b0;
      held_q    <= '0;
    end else begin
      holding_q <= holding_d;
      held_q    <= held_d;
    end
  end
endmodule

// File: design/hc2_emit.sv
// Job register, modulo-26 letter mapping and the result register.
module hc2_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_load_i,
  input  hc2_pkg::job_t             job_i,
  input  logic                      out_ready_i,
  output logic                      job_free_o,
  output logic                      out_valid_o,
  output logic [hc2_pkg::CHAR_W-1:0] char_o,
  output logic                      last_o
);
  import hc2_pkg::*;

  job_t              job_q, job_d;
  logic              job_valid_q, job_valid_d;
  logic              phase_q, phase_d;     // set once the first of a pair has gone
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              out_load, emit, job_fin;

  assign out_load   = !out_valid_q || out_ready_i;
  assign emit       = job_valid_q && out_load;
  assign job_fin    = emit && (job_q.lone || phase_q);
  assign job_free_o = !job_valid_q || job_fin;

  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    phase_d     = phase_q;
    if (job_load_i) begin
      job_d       = job_i;
      job_valid_d = 1'b1;
      phase_d     = 1'b0;
    end else if (job_fin) begin
      job_valid_d = 1'b0;
      phase_d     = 1'b0;
    end else if (emit) begin
      phase_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (job_q.lone) begin
        char_d = job_q.lone_char;
        last_d = 1'b1;
      end else if (phase_q) begin
        char_d = to_letter(job_q.sum1);
        last_d = job_q.last;
      end else begin
        char_d = to_letter(job_q.sum0);
        last_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_o      = char_q;
  assign last_o      = last_q;
endmodule

// File: design/hill_cipher_2x2_letters_core.sv
// 2x2 Hill cipher over a byte stream, working on pairs of letters. The first byte of a
// pair is held; when its partner arrives both are lower-cased, reduced modulo 96 and
// multiplied by the key selected by the decrypt register (bit 0 at address 0), and two
// letters a..z leave on the result channel. A lone final byte leaves unchanged. The
// block takes one byte per cycle while the job register has room. Each result passes
// through the one-entry job register, between the pairing logic and the result
// register, and then the result register. The byte that completes a pair, or a lone
// final byte, is taken only once the job register is empty or its previous job is
// leaving it, so a lone final byte straight after a pair waits for the pair to finish.
module hill_cipher_2x2_letters_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  hc2_in_if.sink                    in_i,
  hc2_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hc2_pkg::ADDR_W-1:0] paddr,
  input  logic [hc2_pkg::DATA_W-1:0] pwdata,
  output logic [hc2_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import hc2_pkg::*;

  logic decrypt;
  logic job_free;
  logic job_load;
  job_t job;

  hc2_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .decrypt_o (decrypt)
  );

  hc2_pair u_pair (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .char_i     (in_i.char_in),
    .last_i     (in_i.last_in),
    .decrypt_i  (decrypt),
    .job_free_i (job_free),
    .ready_o    (in_i.ready),
    .job_load_o (job_load),
    .job_o      (job)
  );

  hc2_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_load_i  (job_load),
    .job_i       (job),
    .out_ready_i (out_o.ready),
    .job_free_o  (job_free),
    .out_valid_o (out_o.valid),
    .char_o      (out_o.char_out),
    .last_o      (out_o.last_out)
  );
endmodule

// File: design/hc2_checker.sv
// Port-level checks for the Hill cipher core, bound to its top level.
module hc2_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [hc2_pkg::CHAR_W-1:0] out_char,
  input  logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hc2_pkg::ADDR_W-1:0] paddr,
  input  logic [hc2_pkg::DATA_W-1:0] pwdata,
  input  logic [hc2_pkg::DATA_W-1:0] prdata,
  input  logic                      pready
);
  import hc2_pkg::*;

  logic in_xfer;
  logic cfg_wr;

  assign in_xfer = in_valid && in_ready;
  assign cfg_wr  = psel && penable && pwrite && pready && !paddr[ADDR_W-1];

  // A stalled result keeps its byte and end mark.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_char)
      && $stable(out_last))
    else $error("result changed while stalled");

  // A new result follows an input transfer through the job and result registers.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_xfer, 2))
    else $error("result appeared without a causing input transfer");

  // Every result that is not the final one is a ciphered lower-case letter.
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |->
      out_char > CHAR_BEFORE_A && out_char <= CHAR_LOWER_Z)
    else $error("non-final result is not a letter");

  // The decrypt register reads back what was last written.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr ##1 !paddr[ADDR_W-1] |-> prdata[0] == $past(pwdata[0]))
    else $error("decrypt register read-back mismatch");
endmodule

bind hill_cipher_2x2_letters_core hc2_checker u_hc2_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_char  (out_o.char_out),
  .out_last  (out_o.last_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
